// ===== rtl/lru_key_value_cache_unit_assert.svh =====
// assertion macros for the lru key/value cache
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define LRUKV_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lru cache invariant violated");

// consequence holds in the cycle after the antecedent
`define LRUKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru cache next-cycle check failed");

`endif

// ===== rtl/lrukv_pkg.sv =====
`default_nettype none

package lrukv_pkg;

   // geometry
   localparam int ENTRIES = 16;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef logic [DATA_W-1:0]               data_type;
   typedef logic [RANK_W-1:0]               rank_type;
   typedef logic [CNT_W-1:0]                count_type;
   typedef logic [CAP_W-1:0]                cap_type;
   typedef logic [ENTRIES-1:0]              mask_type;
   typedef logic [ENTRIES-1:0][DATA_W-1:0]  data_array_type;
   typedef logic [ENTRIES-1:0][RANK_W-1:0]  rank_array_type;

   localparam data_type MISS_VALUE = '1;

   // result of the parallel key compare
   typedef struct packed {
      logic     hit;
      mask_type match;
      rank_type rank;
      data_type value;
   } lookup_type;

   // occupancy status of the entry store
   typedef struct packed {
      count_type occupied;
      mask_type  valid;
   } status_type;

   // capacity register clamped to 1 .. ENTRIES
   function automatic count_type eff_capacity(input cap_type cap);
      count_type result;
      if (cap == '0) begin
         result = CNT_W'(1);
      end else if (int'(cap) > ENTRIES) begin
         result = CNT_W'(ENTRIES);
      end else begin
         result = CNT_W'(cap);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lrukv_lookup.sv =====
`default_nettype none

module lrukv_lookup
   import lrukv_pkg::*;
(
   input  data_type       key,
   input  data_array_type keys,
   input  data_array_type values,
   input  rank_array_type ranks,
   input  mask_type       valid,
   output lookup_type     lookup
);

   // compare against every valid entry, and-or select the matching one
   always_comb begin
      lookup = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lookup.match[i] = valid[i] && (keys[i] == key);
         lookup.value    = lookup.value | ({DATA_W{lookup.match[i]}} & values[i]);
         lookup.rank     = lookup.rank  | ({RANK_W{lookup.match[i]}} & ranks[i]);
      end
      lookup.hit = |lookup.match;
   end

endmodule

`default_nettype wire

// ===== rtl/lrukv_store.sv =====
`default_nettype none

module lrukv_store
   import lrukv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       cmd,
   input  data_type   key,
   input  data_type   value,
   input  cap_type    capacity,
   output logic       resp_hit,
   output data_type   resp_value,
   output status_type status
);

   data_array_type keys_ff, keys_in;
   data_array_type values_ff, values_in;
   rank_array_type ranks_ff, ranks_in;
   mask_type       valid_ff, valid_in;
   count_type      occupied_ff, occupied_in;

   lookup_type lookup;
   logic       full;
   logic       insert;
   logic       touch;
   rank_type   last_rank;
   mask_type   evict_mask;
   mask_type   valid_kept;
   mask_type   free_mask;
   mask_type   slot_mask;

   lrukv_lookup u_lookup (
      .key    (key),
      .keys   (keys_ff),
      .values (values_ff),
      .ranks  (ranks_ff),
      .valid  (valid_ff),
      .lookup (lookup)
   );

   // victim is the valid entry holding the oldest rank
   always_comb begin
      full      = occupied_ff >= eff_capacity(capacity);
      last_rank = RANK_W'(occupied_ff - CNT_W'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         evict_mask[i] = full && valid_ff[i] && (ranks_ff[i] == last_rank);
      end
      valid_kept = valid_ff & ~evict_mask;
      free_mask  = ~valid_kept;
      slot_mask  = free_mask & (~free_mask + mask_type'(1));
   end

   assign touch  = fire && lookup.hit;
   assign insert = fire && (cmd == CMD_PUT) && !lookup.hit;

   // next state of the entries
   always_comb begin
      keys_in     = keys_ff;
      values_in   = values_ff;
      ranks_in    = ranks_ff;
      valid_in    = valid_ff;
      occupied_in = occupied_ff;
      if (touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && (ranks_ff[i] < lookup.rank)) begin
               ranks_in[i] = ranks_ff[i] + RANK_W'(1);
            end
            if (lookup.match[i]) begin
               ranks_in[i] = '0;
               if (cmd == CMD_PUT) begin
                  values_in[i] = value;
               end
            end
         end
      end else if (insert) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (evict_mask[i]) begin
               valid_in[i] = 1'b0;
               ranks_in[i] = '0;
            end
            if (valid_kept[i]) begin
               ranks_in[i] = ranks_ff[i] + RANK_W'(1);
            end
            if (slot_mask[i]) begin
               keys_in[i]   = key;
               values_in[i] = value;
               valid_in[i]  = 1'b1;
               ranks_in[i]  = '0;
            end
         end
         occupied_in = full ? occupied_ff : occupied_ff + CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ranks_ff    <= '0;
         occupied_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         ranks_ff    <= ranks_in;
         occupied_ff <= occupied_in;
      end
   end

   // key and value storage
   always_ff @(posedge clock) begin
      keys_ff   <= keys_in;
      values_ff <= values_in;
   end

   // response of this transaction
   assign resp_hit   = lookup.hit;
   assign resp_value = ((cmd == CMD_GET) && lookup.hit) ? lookup.value : MISS_VALUE;

   assign status.occupied = occupied_ff;
   assign status.valid    = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
// channel    direction  handshake            payload
// req        in         req_valid/req_ready  req_cmd, req_lookup_key, req_store_value
// rsp        out        rsp_valid/rsp_ready  rsp_hit, rsp_read_value
// csr        in         csr_write_enable     csr_write_data (capacity_in_use)
//
// One transaction per cycle sustained while rsp is not stalled. A request goes to the
// input register, then lookup and entry update in one pass into the result register.
// The full 16-way key compare and rank update of the flop-based entry store set the pass.
// Synchronous active-high reset empties the cache and sets capacity to 16.
// A stalled rsp holds the input register full; req_ready then drops until rsp moves.
`default_nettype none
`include "lru_key_value_cache_unit_assert.svh"

module lru_key_value_cache_unit
   import lrukv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [31:0] req_lookup_key,
   input  logic signed [31:0] req_store_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);

   logic       stage_valid_ff, stage_valid_in;
   logic       stage_cmd_ff;
   data_type   stage_key_ff;
   data_type   stage_value_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_hit_ff;
   data_type   rsp_value_ff;
   cap_type    capacity_ff;

   logic       advance;
   logic       req_fire;
   logic       resp_hit;
   data_type   resp_value;
   status_type status;

   logic       occupancy_ok;
   logic       put_fire;
   logic       evict_fire;
   logic       stall;

   // handshake control
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         capacity_ff    <= CAP_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_cmd_ff   <= req_cmd;
         stage_key_ff   <= data_type'(req_lookup_key);
         stage_value_ff <= data_type'(req_store_value);
      end
   end

   // entry store with lookup and lru update
   lrukv_store u_store (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .cmd        (stage_cmd_ff),
      .key        (stage_key_ff),
      .value      (stage_value_ff),
      .capacity   (capacity_ff),
      .resp_hit   (resp_hit),
      .resp_value (resp_value),
      .status     (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff   <= resp_hit;
         rsp_value_ff <= resp_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = $signed(rsp_value_ff);

   // checks
   assign occupancy_ok = status.occupied == CNT_W'($countones(status.valid));
   assign put_fire     = advance && (stage_cmd_ff == CMD_PUT);
   assign evict_fire   = put_fire && !resp_hit && (status.occupied >= eff_capacity(capacity_ff));
   assign stall        = stage_valid_ff && !advance;

   `LRUKV_ASSERT_ALWAYS(a_occupancy_matches_valid, clock, reset, occupancy_ok)
   `LRUKV_ASSERT_NEXT(a_put_returns_miss, clock, reset, put_fire, rsp_value_ff == MISS_VALUE)
   `LRUKV_ASSERT_NEXT(a_evict_keeps_occupancy, clock, reset, evict_fire, $stable(status.occupied))
   `LRUKV_ASSERT_NEXT(a_stage_holds, clock, reset, stall, stage_valid_ff && $stable(stage_key_ff))

endmodule

`default_nettype wire

// ===== dv/tb_lru_key_value_cache_unit.sv =====
module tb_lru_key_value_cache_unit;
   import lrukv_pkg::*;

   // what one request must return
   typedef struct packed {
      logic     hit;
      data_type value;
   } lookup_result_type;

   // shadow copy of the cache and the results it still owes
   class lru_shadow_cache;
      data_type          slot_key[ENTRIES];
      data_type          slot_value[ENTRIES];
      logic              slot_live[ENTRIES];
      rank_type          slot_age[ENTRIES];
      count_type         live_count;
      cap_type           capacity;
      lookup_result_type awaited[$];
      int                mismatches;

      function new();
         capacity   = CAP_RESET;
         live_count = '0;
         mismatches = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_live[i]  = 1'b0;
            slot_age[i]   = '0;
         end
      endfunction

      // zero behaves as one, anything past the store size saturates
      function int entry_limit();
         int lim;
         lim = int'(capacity);
         if (lim == 0) lim = 1;
         if (lim > ENTRIES) lim = ENTRIES;
         return lim;
      endfunction

      // entries younger than idx age by one, idx becomes rank zero
      function void promote(int idx);
         rank_type r;
         r = slot_age[idx];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
         slot_age[idx] = '0;
      endfunction

      function void drop_oldest();
         int       victim;
         rank_type oldest;
         victim = -1;
         oldest = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && (victim < 0 || slot_age[i] >= oldest)) begin
               victim = i;
               oldest = slot_age[i];
            end
         end
         if (victim >= 0) begin
            slot_live[victim] = 1'b0;
            slot_age[victim]  = '0;
            if (live_count != '0) live_count--;
         end
      endfunction

      function void note_request(logic cmd, data_type key, data_type val);
         int                found;
         int                free_slot;
         lookup_result_type res;
         found     = -1;
         free_slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key) found = i;
         res.hit   = (found >= 0);
         res.value = MISS_VALUE;
         if (cmd == CMD_GET) begin
            if (found >= 0) begin
               res.value = slot_value[found];
               promote(found);
            end
         end else if (found >= 0) begin
            slot_value[found] = val;
            promote(found);
         end else begin
            // new key: make room when at capacity, take the lowest free slot
            if (int'(live_count) >= entry_limit()) drop_oldest();
            for (int i = 0; i < ENTRIES; i++)
               if (free_slot < 0 && !slot_live[i]) free_slot = i;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_live[i]) slot_age[i]++;
            slot_key[free_slot]   = key;
            slot_value[free_slot] = val;
            slot_live[free_slot]  = 1'b1;
            slot_age[free_slot]   = '0;
            live_count++;
         end
         awaited.push_back(res);
      endfunction

      function void check_response(logic hit, data_type value);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with nothing awaited, expected none actual hit %0b value %h",
                     $time, hit, value);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
            mismatches++;
         end
         if (value !== want.value) begin
            $display("%0t: read value mismatch, expected %h actual %h",
                     $time, want.value, value);
            mismatches++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   localparam data_type KEY_MIN = 32'h8000_0000;
   localparam data_type KEY_MAX = 32'h7FFF_FFFF;
   localparam data_type KEY_ONES = 32'hFFFF_FFFF;

   data_type corner_keys[4] = '{KEY_MIN, KEY_MAX, 32'h0, KEY_ONES};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_GET;
   logic signed [31:0] req_lookup_key = '0;
   logic signed [31:0] req_store_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_hit;
   logic signed [31:0] rsp_read_value;
   logic              csr_write_enable = 1'b0;
   logic [4:0]        csr_write_data = '0;

   lru_shadow_cache sb;
   bit              steady = 1'b0;
   bit              long_hold_wanted = 1'b0;

   lru_key_value_cache_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_lookup_key   (req_lookup_key),
      .req_store_value  (req_store_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_hit, rsp_read_value);
         if (req_valid && req_ready) sb.note_request(req_cmd, req_lookup_key, req_store_value);
      end
   end

   // result side back-pressure: random stalls, one long hold on request
   initial begin : rsp_drain
      int span;
      forever begin
         @(negedge clock);
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            rsp_ready = 1'b0;
            span = 80;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            span = $urandom_range(1, 14);
         end else begin
            rsp_ready = 1'b1;
            span = steady ? 1 : $urandom_range(1, 30);
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   // offer one transaction, returns at the edge that accepts it
   task automatic send_request(input logic cmd, input data_type key, input data_type val);
      @(negedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_lookup_key  = key;
      req_store_value = val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // capacity changes only with the pipeline empty
   task automatic write_capacity(input cap_type cap);
      wait_for_drain();
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = cap;
      sb.capacity      = cap;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // random traffic over a small key pool so hits and evictions both happen
   task automatic run_phase(input cap_type cap, input int count, input int hold_at,
                            input int pause_at);
      data_type pool[24];
      int       pool_size;
      int       lim;
      logic     cmd;
      data_type key;
      write_capacity(cap);
      lim = (cap == '0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : int'(cap));
      pool_size = lim + $urandom_range(0, 6);
      for (int i = 0; i < 24; i++)
         pool[i] = ($urandom_range(0, 7) == 0) ? corner_keys[$urandom_range(0, 3)] : $urandom;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) long_hold_wanted = 1'b1;
         if (n == pause_at) wait_for_drain();
         cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
         key = ($urandom_range(0, 9) == 0) ? data_type'($urandom)
                                           : pool[$urandom_range(0, pool_size - 1)];
         send_request(cmd, key, $urandom);
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: empty lookup, extreme keys and values, update on put
      send_request(CMD_GET, 32'h0, 32'h0);
      send_request(CMD_PUT, KEY_MIN, KEY_MAX);
      send_request(CMD_PUT, KEY_MAX, KEY_MIN);
      send_request(CMD_PUT, 32'h0, 32'h0);
      send_request(CMD_PUT, KEY_ONES, KEY_ONES);
      send_request(CMD_GET, KEY_MIN, 32'h0);
      send_request(CMD_GET, KEY_MAX, 32'h0);
      send_request(CMD_GET, 32'h0, KEY_ONES);
      send_request(CMD_GET, KEY_ONES, 32'h0);
      send_request(CMD_GET, 32'h1234_5678, 32'h0);
      send_request(CMD_PUT, 32'h0, 32'hA5A5_5A5A);
      send_request(CMD_GET, 32'h0, 32'h0);
      send_request(CMD_PUT, KEY_MIN, 32'h5A5A_A5A5);

      // capacity lowered below occupancy: each insert replaces the oldest
      write_capacity(5'd2);
      send_request(CMD_PUT, 32'h1, 32'h1);
      send_request(CMD_GET, KEY_MAX, 32'h0);
      send_request(CMD_PUT, 32'h2, 32'h2);
      send_request(CMD_GET, 32'h1, 32'h0);

      // zero capacity acts as one
      write_capacity(5'd0);
      send_request(CMD_PUT, 32'h3, 32'h3);
      send_request(CMD_GET, 32'h3, 32'h0);
      send_request(CMD_GET, KEY_MIN, 32'h0);

      // capacity above the store size saturates
      write_capacity(5'd31);
      send_request(CMD_PUT, 32'h4, 32'h4);
      send_request(CMD_GET, 32'h2, 32'h0);

      run_phase(5'd16, 250, -1, 120);
      run_phase(5'd0, 120, -1, -1);
      run_phase(5'd1, 120, -1, -1);
      run_phase(5'd31, 200, 60, -1);
      run_phase(5'd4, 200, -1, -1);
      run_phase(5'd17, 150, 40, -1);
      run_phase(5'd8, 200, -1, -1);
      run_phase(5'd2, 150, -1, -1);
      run_phase(cap_type'($urandom_range(0, 31)), 150, -1, -1);
      steady = 1'b1;
      run_phase(5'd16, 200, -1, -1);

      wait_for_drain();
      repeat (6) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_lru_key_value_cache_unit: done, clean");
      end else begin
         $display("tb_lru_key_value_cache_unit: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #1000000;
      $display("tb_lru_key_value_cache_unit: done, errors");
      $finish;
   end

endmodule
